>>> hdl/tcqs_pkg.sv
package tcqs_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int NUM_SLOTS_DEF    = 4;
    localparam int ARRIVAL_BITS_DEF = 16;

    localparam int ID_W       = 30;
    localparam int MODE_W     = 2;
    localparam int SLOT_IDX_W = 3;
    localparam int STATUS_W   = 3;
    localparam int OUT_ARR_W  = 16;
    localparam int AGING_W    = 8;

    localparam logic [AGING_W-1:0] AGING_RESET = 8'd5;

    // input modes
    localparam logic [MODE_W-1:0] MODE_ENQ_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENQ_PRIO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISPATCH   = 2'd2;

    // command kinds after classification
    localparam logic [1:0] KIND_ENQ_NORMAL = 2'd0;
    localparam logic [1:0] KIND_ENQ_PRIO   = 2'd1;
    localparam logic [1:0] KIND_DISPATCH   = 2'd2;
    localparam logic [1:0] KIND_INVALID    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_ENQUEUED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DROPPED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SLOT_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT    = 3'd4;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ID_W-1:0]       id;
        logic [SLOT_IDX_W-1:0] slot;
    } t_cmd;

endpackage

>>> hdl/tcqs_ram.sv
module tcqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tcqs_front.sv
module tcqs_front #(
    parameter int NUM_SLOTS = tcqs_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tcqs_pkg::MODE_W-1:0]         i_mode,
    input  logic [tcqs_pkg::ID_W-1:0]           i_client_id,
    input  logic [tcqs_pkg::SLOT_IDX_W-1:0]     i_slot_index,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output tcqs_pkg::t_cmd                      o_cmd
);

    tcqs_pkg::t_cmd r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    tcqs_pkg::t_cmd new_cmd;
    logic           push;
    logic           pop;

    // classify: dispatches to out-of-range slots and the unused mode become one invalid kind
    always_comb begin
        new_cmd.id   = i_client_id;
        new_cmd.slot = i_slot_index;
        unique case (i_mode)
            tcqs_pkg::MODE_ENQ_NORMAL: new_cmd.kind = tcqs_pkg::KIND_ENQ_NORMAL;
            tcqs_pkg::MODE_ENQ_PRIO:   new_cmd.kind = tcqs_pkg::KIND_ENQ_PRIO;
            tcqs_pkg::MODE_DISPATCH: begin
                if ({1'b0, i_slot_index} < (tcqs_pkg::SLOT_IDX_W + 1)'(NUM_SLOTS)) begin
                    new_cmd.kind = tcqs_pkg::KIND_DISPATCH;
                end else begin
                    new_cmd.kind = tcqs_pkg::KIND_INVALID;
                end
            end
            default: new_cmd.kind = tcqs_pkg::KIND_INVALID;
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_entry[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= new_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> hdl/tcqs_back.sv
module tcqs_back #(
    parameter int QUEUE_DEPTH  = tcqs_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_SLOTS    = tcqs_pkg::NUM_SLOTS_DEF,
    parameter int ARRIVAL_BITS = tcqs_pkg::ARRIVAL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcqs_pkg::AGING_W-1:0]        i_cfg_data,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  tcqs_pkg::t_cmd                      i_cmd,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tcqs_pkg::STATUS_W-1:0]       o_status,
    output logic [tcqs_pkg::ID_W-1:0]           o_released_id,
    output logic                                o_assigned_valid,
    output logic [tcqs_pkg::ID_W-1:0]           o_assigned_id,
    output logic                                o_assigned_from_priority,
    output logic [tcqs_pkg::OUT_ARR_W-1:0]      o_assigned_arrival,
    output logic [tcqs_pkg::OUT_ARR_W-1:0]      o_arrival_stamp
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW    = tcqs_pkg::ID_W;
    localparam int AB    = ARRIVAL_BITS;
    localparam int EW    = AB + IW;
    localparam int EXT_W = (AB > tcqs_pkg::OUT_ARR_W) ? AB : tcqs_pkg::OUT_ARR_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]                   r_state;
    logic [tcqs_pkg::AGING_W-1:0] r_aging;
    logic [PW-1:0]                r_n_head, r_n_tail, r_p_head, r_p_tail;
    logic [CW-1:0]                r_n_cnt, r_p_cnt;
    logic [AB-1:0]                r_arrival;
    logic                         r_busy [NUM_SLOTS];
    logic [IW-1:0]                r_client [NUM_SLOTS];
    logic [SW-1:0]                r_slot;
    logic                         r_out_valid;

    logic [tcqs_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [IW-1:0]                  r_released, n_released;
    logic                           r_asg_v, n_asg_v;
    logic [IW-1:0]                  r_asg_id, n_asg_id;
    logic                           r_asg_p, n_asg_p;
    logic [tcqs_pkg::OUT_ARR_W-1:0] r_asg_arr, n_asg_arr;
    logic [tcqs_pkg::OUT_ARR_W-1:0] r_stamp, n_stamp;

    logic          out_free, hand, dec, load_out;
    logic          n_full, p_full, n_we, p_we;
    logic [AB-1:0] stamp;
    logic [EW-1:0] n_rd, p_rd, wdata;
    logic [AB-1:0] n_arr, p_arr, gap;
    logic          n_any, p_any, normal_wins, take_prio;
    logic [SW-1:0] cmd_slot;
    logic [PW-1:0] n_head_inc, n_tail_inc, p_head_inc, p_tail_inc;
    logic [EXT_W-1:0] stamp_ext, asg_arr_ext;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && out_free;
    assign hand        = i_cmd_valid && o_cmd_ready;
    assign dec         = (r_state == ST_DECIDE) && out_free;
    assign cmd_slot    = i_cmd.slot[SW-1:0];

    assign n_full = (r_n_cnt == CW'(QUEUE_DEPTH));
    assign p_full = (r_p_cnt == CW'(QUEUE_DEPTH));
    assign stamp  = r_arrival + 1'b1;
    assign wdata  = {stamp, i_cmd.id};
    assign n_we   = hand && (i_cmd.kind == tcqs_pkg::KIND_ENQ_NORMAL) && !n_full;
    assign p_we   = hand && (i_cmd.kind == tcqs_pkg::KIND_ENQ_PRIO) && !p_full;

    assign n_head_inc = (r_n_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_n_head + 1'b1;
    assign n_tail_inc = (r_n_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_n_tail + 1'b1;
    assign p_head_inc = (r_p_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_p_head + 1'b1;
    assign p_tail_inc = (r_p_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_p_tail + 1'b1;

    tcqs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_n_tail),
        .i_wdata (wdata),
        .i_raddr (r_n_head),
        .o_rdata (n_rd)
    );

    tcqs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_p_tail),
        .i_wdata (wdata),
        .i_raddr (r_p_head),
        .o_rdata (p_rd)
    );

    // head entries are registered out of the RAMs during ST_READ
    assign n_arr = n_rd[EW-1:IW];
    assign p_arr = p_rd[EW-1:IW];
    assign n_any = (r_n_cnt != '0);
    assign p_any = (r_p_cnt != '0);
    assign gap   = p_arr - n_arr;
    // the upper half of the gap counts as negative
    assign normal_wins = !gap[AB-1] && (gap > AB'(r_aging));
    assign take_prio   = p_any && !(n_any && normal_wins);

    assign stamp_ext   = EXT_W'(stamp);
    assign asg_arr_ext = EXT_W'(take_prio ? p_arr : n_arr);

    always_comb begin
        n_status   = tcqs_pkg::STAT_NO_SLOT;
        n_released = '0;
        n_asg_v    = 1'b0;
        n_asg_id   = '0;
        n_asg_p    = 1'b0;
        n_asg_arr  = '0;
        n_stamp    = '0;
        if (r_state == ST_DECIDE) begin
            if (r_busy[r_slot]) begin
                n_status   = tcqs_pkg::STAT_RELEASED;
                n_released = r_client[r_slot];
            end else begin
                n_status = tcqs_pkg::STAT_SLOT_EMPTY;
            end
            if (p_any || n_any) begin
                n_asg_v   = 1'b1;
                n_asg_id  = take_prio ? p_rd[IW-1:0] : n_rd[IW-1:0];
                n_asg_p   = take_prio;
                n_asg_arr = asg_arr_ext[tcqs_pkg::OUT_ARR_W-1:0];
            end
        end else begin
            unique case (i_cmd.kind)
                tcqs_pkg::KIND_ENQ_NORMAL: begin
                    n_status = n_full ? tcqs_pkg::STAT_DROPPED : tcqs_pkg::STAT_ENQUEUED;
                    n_stamp  = n_full ? '0 : stamp_ext[tcqs_pkg::OUT_ARR_W-1:0];
                end
                tcqs_pkg::KIND_ENQ_PRIO: begin
                    n_status = p_full ? tcqs_pkg::STAT_DROPPED : tcqs_pkg::STAT_ENQUEUED;
                    n_stamp  = p_full ? '0 : stamp_ext[tcqs_pkg::OUT_ARR_W-1:0];
                end
                default: n_status = tcqs_pkg::STAT_NO_SLOT;
            endcase
        end
    end

    assign load_out = (hand && (i_cmd.kind != tcqs_pkg::KIND_DISPATCH)) || dec;

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status   <= n_status;
            r_released <= n_released;
            r_asg_v    <= n_asg_v;
            r_asg_id   <= n_asg_id;
            r_asg_p    <= n_asg_p;
            r_asg_arr  <= n_asg_arr;
            r_stamp    <= n_stamp;
        end
        if (dec && (p_any || n_any)) begin
            r_client[r_slot] <= n_asg_id;
        end
        if (hand) begin
            r_slot <= cmd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_aging     <= tcqs_pkg::AGING_RESET;
            r_n_head    <= '0;
            r_n_tail    <= '0;
            r_n_cnt     <= '0;
            r_p_head    <= '0;
            r_p_tail    <= '0;
            r_p_cnt     <= '0;
            r_arrival   <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_busy[s] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_aging <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (n_we) begin
                r_n_tail  <= n_tail_inc;
                r_n_cnt   <= r_n_cnt + 1'b1;
                r_arrival <= stamp;
            end
            if (p_we) begin
                r_p_tail  <= p_tail_inc;
                r_p_cnt   <= r_p_cnt + 1'b1;
                r_arrival <= stamp;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (hand && (i_cmd.kind == tcqs_pkg::KIND_DISPATCH)) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (dec) begin
                        r_state        <= ST_IDLE;
                        r_busy[r_slot] <= p_any || n_any;
                        if (take_prio) begin
                            r_p_head <= p_head_inc;
                            r_p_cnt  <= r_p_cnt - 1'b1;
                        end else if (n_any) begin
                            r_n_head <= n_head_inc;
                            r_n_cnt  <= r_n_cnt - 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_status                 = r_status;
    assign o_released_id            = r_released;
    assign o_assigned_valid         = r_asg_v;
    assign o_assigned_id            = r_asg_id;
    assign o_assigned_from_priority = r_asg_p;
    assign o_assigned_arrival       = r_asg_arr;
    assign o_arrival_stamp          = r_stamp;

endmodule

>>> hdl/two_class_queue_scheduler.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_mode, i_client_id, i_slot_index
// result    out        o_out_valid / i_out_ready  o_status .. o_arrival_stamp
// config    in         i_cfg_we                   i_cfg_data (aging window)
//
// An enqueue or a rejected command takes only the back end's accept step;
// a dispatch goes through accept, registered read of the queue RAM heads and
// decide. A result is registered when the back end accepts an enqueue or a
// rejected command, and in the decide step for a dispatch.
// A 2-entry command queue sits between the classifier and the back end.
// Reset is synchronous, active low; queue storage needs no clearing pass.
// A stalled result holds the back end, the command queue then fills and
// drops o_in_ready.
module two_class_queue_scheduler #(
    parameter int QUEUE_DEPTH  = tcqs_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_SLOTS    = tcqs_pkg::NUM_SLOTS_DEF,
    parameter int ARRIVAL_BITS = tcqs_pkg::ARRIVAL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcqs_pkg::AGING_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tcqs_pkg::MODE_W-1:0]         i_mode,
    input  logic [tcqs_pkg::ID_W-1:0]           i_client_id,
    input  logic [tcqs_pkg::SLOT_IDX_W-1:0]     i_slot_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tcqs_pkg::STATUS_W-1:0]       o_status,
    output logic [tcqs_pkg::ID_W-1:0]           o_released_id,
    output logic                                o_assigned_valid,
    output logic [tcqs_pkg::ID_W-1:0]           o_assigned_id,
    output logic                                o_assigned_from_priority,
    output logic [tcqs_pkg::OUT_ARR_W-1:0]      o_assigned_arrival,
    output logic [tcqs_pkg::OUT_ARR_W-1:0]      o_arrival_stamp
);

    logic           cmd_valid;
    logic           cmd_ready;
    tcqs_pkg::t_cmd cmd;

    tcqs_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_client_id  (i_client_id),
        .i_slot_index (i_slot_index),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    tcqs_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NUM_SLOTS    (NUM_SLOTS),
        .ARRIVAL_BITS (ARRIVAL_BITS)
    ) u_back (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_data               (i_cfg_data),
        .i_cmd_valid              (cmd_valid),
        .o_cmd_ready              (cmd_ready),
        .i_cmd                    (cmd),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_status                 (o_status),
        .o_released_id            (o_released_id),
        .o_assigned_valid         (o_assigned_valid),
        .o_assigned_id            (o_assigned_id),
        .o_assigned_from_priority (o_assigned_from_priority),
        .o_assigned_arrival       (o_assigned_arrival),
        .o_arrival_stamp          (o_arrival_stamp)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_assign_on_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_assigned_valid) |->
            (o_status == tcqs_pkg::STAT_SLOT_EMPTY || o_status == tcqs_pkg::STAT_RELEASED))
        else $error("assignment reported on a non-dispatch result");

    a_enqueue_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == tcqs_pkg::STAT_ENQUEUED) |->
            (o_released_id == '0 && o_assigned_id == '0))
        else $error("enqueue result carries dispatch fields");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == tcqs_pkg::STAT_DROPPED ||
                         o_status == tcqs_pkg::STAT_NO_SLOT)) |->
            (o_arrival_stamp == '0 && !o_assigned_from_priority))
        else $error("rejected item carries a stamp or assignment");

    a_cmd_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_ready && !cmd_valid && !o_out_valid) |=> !o_out_valid)
        else $error("result produced without a command");

endmodule
